@@ rtl/fgpl_pkg.sv @@
`timescale 1ns / 1ps
// fgpl_pkg: shared types and constants for the fuel gauge block.
// No dependencies.

package fgpl_pkg;

  localparam int ADC_W  = 12;             // width of the sample field
  localparam int CODE_W = 12;             // breakpoint register width
  localparam int CAP_W  = 14;             // tank capacity register width
  localparam int BP_W   = CODE_W + 4;     // breakpoint in Q.4
  localparam int PCT_W  = 15;
  localparam int CL_W   = 17;
  localparam int RS_W   = 2;
  localparam int DVD_W  = 29;             // dividend / quotient width
  localparam int DVS_W  = 16;             // divisor width
  localparam int DCNT_W = $clog2(DVD_W);
  localparam int MUL_W  = 30;

  localparam logic [PCT_W-1:0] SEG_STEP = 15'd6400;
  localparam logic [PCT_W-1:0] PCT_FULL = 15'd25600;
  localparam logic [DVS_W-1:0] CL_DIV   = 16'd2560;
  localparam logic [CL_W-1:0]  CL_MAX   = 17'd131071;

  localparam logic [RS_W-1:0] RS_ON_CURVE    = 2'd0;
  localparam logic [RS_W-1:0] RS_ABOVE_EMPTY = 2'd1;
  localparam logic [RS_W-1:0] RS_BELOW_FULL  = 2'd2;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = CAP_W;
  localparam logic [CFG_IDX_W-1:0] REG_EMPTY    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUARTER  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HALF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THREE_Q  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd5;

  typedef struct packed {
    logic busy;
    logic done;
  } fgpl_div_stat_t;

endpackage

@@ rtl/fgpl_div.sv @@
`timescale 1ns / 1ps
// fgpl_div: restoring divider, one quotient bit per cycle.
// Depends on fgpl_pkg.

module fgpl_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [fgpl_pkg::DVD_W-1:0]   dividend,
  input  logic [fgpl_pkg::DVS_W-1:0]   divisor,
  output fgpl_pkg::fgpl_div_stat_t     stat,
  output logic [fgpl_pkg::DVD_W-1:0]   quotient
);
  import fgpl_pkg::*;

  logic [DVS_W-1:0]  rem;
  logic [DVS_W-1:0]  dvs;
  logic [DVD_W-1:0]  quo;
  logic [DCNT_W-1:0] cnt;
  logic              busy;
  logic              done;
  logic [DVS_W:0]    trial;

  assign trial = {rem, quo[DVD_W-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == DCNT_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      dvs <= divisor;
      rem <= '0;
    end else if (busy) begin
      if (!trial[DVS_W]) begin
        rem <= trial[DVS_W-1:0];
      end else begin
        rem <= {rem[DVS_W-2:0], quo[DVD_W-1]};
      end
      quo <= {quo[DVD_W-2:0], ~trial[DVS_W]};
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign quotient  = quo;

endmodule

@@ rtl/fuel_gauge_piecewise_linear.sv @@
`timescale 1ns / 1ps
// fuel_gauge_piecewise_linear: averages SAMPLES_PER_READING sender samples and maps
// the average onto a five-point curve, giving percent (Q8) and fuel volume.
// A sample that does not close a reading is added to the sum and s_tready stays high.
// A closing sample inside a segment reaches the output register after three passes
// through one shared restoring divider (average, interpolation, volume), one to four
// segment compares and two shared multiplies. Off the curve or on a zero-width
// segment the interpolation pass is skipped. s_tready stays low until then, and
// also while a finished result waits for the previous one to be taken.
// Synchronous reset clears sum, count, sequencer and output valid; registers reload.
// Depends on fgpl_pkg and fgpl_div.

module fuel_gauge_piecewise_linear #(
  parameter int SAMPLES_PER_READING = 5,
  parameter int ADC_BITS            = 12
) (
  input  logic                              clk,
  input  logic                              rst,
  // config write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fgpl_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fgpl_pkg::CFG_DAT_W-1:0]    cfg_data,
  // sample requests
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [15:0]                       s_tdata,  // [11:0] adc_sample
  // result requests
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [39:0]                       m_tdata   // [14:0] fuel_percent_q8,
                                                      // [31:15] fuel_centiliters,
                                                      // [33:32] range_status
);
  import fgpl_pkg::*;

  localparam int SUM_W = ADC_W + $clog2(SAMPLES_PER_READING);
  localparam int CNT_W = (SAMPLES_PER_READING > 1) ? $clog2(SAMPLES_PER_READING) : 1;
  localparam int SMP_W = (ADC_BITS < ADC_W) ? ADC_BITS : ADC_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_AVG    = 6'b000010,
    ST_SEARCH = 6'b000100,
    ST_MUL    = 6'b001000,
    ST_DIV    = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state;

  logic [CODE_W-1:0] empty_code, quarter_code, half_code, three_quarter_code, full_code;
  logic [CAP_W-1:0]  capacity;

  logic [SUM_W-1:0]  sum;
  logic [CNT_W-1:0]  count;
  logic [BP_W-1:0]   avg;
  logic [1:0]        seg;
  logic              vol;
  logic [DVD_W-1:0]  prod;
  logic [PCT_W-1:0]  pct;
  logic [RS_W-1:0]   status;
  logic [CL_W-1:0]   cl;
  logic              div_start;

  logic [SUM_W-1:0]  sample_ext;
  logic [SUM_W-1:0]  sum_next;
  logic [BP_W-1:0]   bp_hi, bp_lo, bp_empty;
  logic [PCT_W-1:0]  base;
  logic              hit;
  logic [BP_W-1:0]   mul_a;
  logic [CAP_W-1:0]  mul_b;
  logic [MUL_W-1:0]  mul_p;
  logic [DVS_W-1:0]  div_divisor;
  fgpl_div_stat_t    div_stat;
  logic [DVD_W-1:0]  quotient;
  logic              accept;
  logic              out_free;

  assign cfg_ready  = 1'b1;
  assign s_tready   = (state == ST_IDLE);
  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign sample_ext = SUM_W'(s_tdata[SMP_W-1:0]);
  assign sum_next   = sum + sample_ext;
  assign bp_empty   = {empty_code, 4'b0000};

  always_comb begin
    case (seg)
      2'd0: begin
        bp_hi = {empty_code, 4'b0000};
        bp_lo = {quarter_code, 4'b0000};
      end
      2'd1: begin
        bp_hi = {quarter_code, 4'b0000};
        bp_lo = {half_code, 4'b0000};
      end
      2'd2: begin
        bp_hi = {half_code, 4'b0000};
        bp_lo = {three_quarter_code, 4'b0000};
      end
      default: begin
        bp_hi = {three_quarter_code, 4'b0000};
        bp_lo = {full_code, 4'b0000};
      end
    endcase
  end

  assign base  = SEG_STEP * PCT_W'(seg);
  assign hit   = (avg <= bp_hi) && (avg >= bp_lo);
  assign mul_a = vol ? BP_W'(pct) : (bp_hi - avg);
  assign mul_b = vol ? capacity : CAP_W'(SEG_STEP);
  assign mul_p = MUL_W'(mul_a) * MUL_W'(mul_b);

  always_comb begin
    if (state == ST_AVG) begin
      div_divisor = DVS_W'(SAMPLES_PER_READING);
    end else if (vol) begin
      div_divisor = CL_DIV;
    end else begin
      div_divisor = bp_hi - bp_lo;
    end
  end

  fgpl_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod),
    .divisor  (div_divisor),
    .stat     (div_stat),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      empty_code         <= 12'd1415;
      quarter_code       <= 12'd1241;
      half_code          <= 12'd1055;
      three_quarter_code <= 12'd521;
      full_code          <= 12'd149;
      capacity           <= 14'd350;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_EMPTY:    empty_code         <= cfg_data[CODE_W-1:0];
        REG_QUARTER:  quarter_code       <= cfg_data[CODE_W-1:0];
        REG_HALF:     half_code          <= cfg_data[CODE_W-1:0];
        REG_THREE_Q:  three_quarter_code <= cfg_data[CODE_W-1:0];
        REG_FULL:     full_code          <= cfg_data[CODE_W-1:0];
        REG_CAPACITY: capacity           <= cfg_data[CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      sum       <= '0;
      count     <= '0;
      div_start <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      div_start <= 1'b0;
      if (state == ST_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (count == CNT_W'(SAMPLES_PER_READING - 1)) begin
              sum       <= '0;
              count     <= '0;
              prod      <= DVD_W'({sum_next, 4'b0000});
              div_start <= 1'b1;
              state     <= ST_AVG;
            end else begin
              sum   <= sum_next;
              count <= count + 1'b1;
            end
          end
        end
        ST_AVG: begin
          if (div_stat.done) begin
            avg   <= quotient[BP_W-1:0];
            seg   <= 2'd0;
            state <= ST_SEARCH;
          end
        end
        ST_SEARCH: begin
          if (hit) begin
            status <= RS_ON_CURVE;
            if (bp_hi == bp_lo) begin
              pct <= base;
              vol <= 1'b1;
            end else begin
              vol <= 1'b0;
            end
            state <= ST_MUL;
          end else if (seg == 2'd3) begin
            if (avg > bp_empty) begin
              pct    <= '0;
              status <= RS_ABOVE_EMPTY;
            end else begin
              pct    <= PCT_FULL;
              status <= RS_BELOW_FULL;
            end
            vol   <= 1'b1;
            state <= ST_MUL;
          end else begin
            seg <= seg + 1'b1;
          end
        end
        ST_MUL: begin
          prod      <= mul_p[DVD_W-1:0];
          div_start <= 1'b1;
          state     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_stat.done) begin
            if (!vol) begin
              pct   <= base + quotient[PCT_W-1:0];
              vol   <= 1'b1;
              state <= ST_MUL;
            end else begin
              cl    <= (quotient > DVD_W'(CL_MAX)) ? CL_MAX : quotient[CL_W-1:0];
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_tdata  <= {6'b0, status, cl, pct};
            state    <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  a_pct_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[14:0] <= PCT_FULL))
    else $error("percent out of range");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[33:32] != 2'd3))
    else $error("bad range status");

  a_above_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tdata[33:32] == RS_ABOVE_EMPTY) |-> (m_tdata[14:0] == '0))
    else $error("above-empty result not zero");

  a_div_idle_start: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_stat.busy)
    else $error("divider restarted while busy");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(SAMPLES_PER_READING - 1))
    else $error("sample count overran");

endmodule

@@ test/tb_fuel_gauge_piecewise_linear.sv @@
`timescale 1ns / 1ps
// tb_fuel_gauge_piecewise_linear: self-checking bench for the fuel gauge block.
// Drives sample and config requests, predicts every reading and checks each result.
// Depends on fgpl_pkg and fuel_gauge_piecewise_linear.

module tb_fuel_gauge_piecewise_linear;
  import fgpl_pkg::*;

  localparam int READ_LEN      = 5;
  localparam int SETTLE_CYCLES = 120;
  localparam int CYCLE_LIMIT   = 600000;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
  localparam logic [4:0][CFG_IDX_W-1:0] CURVE_REGS =
    {REG_FULL, REG_THREE_Q, REG_HALF, REG_QUARTER, REG_EMPTY};

  typedef struct packed {
    logic [RS_W-1:0]  status;
    logic [CL_W-1:0]  cl;
    logic [PCT_W-1:0] pct;
  } gauge_reading_t;

  logic                 clk       = 1'b0;
  logic                 rst       = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DAT_W-1:0] cfg_data  = '0;
  logic                 s_tvalid  = 1'b0;
  logic                 s_tready;
  logic [15:0]          s_tdata   = '0;
  logic                 m_tvalid;
  logic                 m_tready  = 1'b0;
  logic [39:0]          m_tdata;

  // predictor state
  logic [4:0][CODE_W-1:0] curve_code;
  logic [CAP_W-1:0]       tank_cap;
  logic [14:0]            acc_sum;
  int                     acc_count;
  gauge_reading_t         pending_readings[$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int samples_sent   = 0;
  bit no_gaps        = 1'b0;

  fuel_gauge_piecewise_linear #(
    .SAMPLES_PER_READING(READ_LEN),
    .ADC_BITS(ADC_W)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= no_gaps || ($urandom_range(99) >= 15);
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("MISMATCH cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatch_count++;
  endtask

  function automatic gauge_reading_t map_average(input int unsigned avg);
    int unsigned    bp [5];
    int unsigned    width;
    int unsigned    pct;
    longint unsigned vol;
    bit             hit;
    gauge_reading_t r;
    for (int k = 0; k < 5; k++) bp[k] = 32'(curve_code[k]) << 4;
    hit = 1'b0;
    pct = 32'(PCT_FULL);
    r.status = RS_BELOW_FULL;
    for (int i = 0; i < 4; i++) begin
      if (!hit && avg <= bp[i] && avg >= bp[i+1]) begin
        hit = 1'b1;
        r.status = RS_ON_CURVE;
        width = bp[i] - bp[i+1];
        pct = 32'(SEG_STEP) * i;
        if (width != 0) pct = pct + ((bp[i] - avg) * 32'(SEG_STEP)) / width;
      end
    end
    if (!hit && avg > bp[0]) begin
      pct = 0;
      r.status = RS_ABOVE_EMPTY;
    end
    vol = (64'(pct) * tank_cap) / CL_DIV;
    if (vol > CL_MAX) vol = CL_MAX;
    r.pct = pct[PCT_W-1:0];
    r.cl  = vol[CL_W-1:0];
    return r;
  endfunction

  task automatic accumulate_sample(input logic [ADC_W-1:0] smp);
    int unsigned avg;
    acc_sum = acc_sum + smp;
    acc_count++;
    if (acc_count == READ_LEN) begin
      avg = (32'(acc_sum) * 16) / READ_LEN;
      acc_sum = '0;
      acc_count = 0;
      pending_readings.push_back(map_average(avg));
    end
  endtask

  always @(posedge clk) begin : check_results
    gauge_reading_t got;
    gauge_reading_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[33:0];
      if (pending_readings.size() == 0) begin
        report_mismatch("unexpected reading, percent", got.pct, 0);
      end else begin
        want = pending_readings.pop_front();
        if (got.pct != want.pct) report_mismatch("fuel_percent_q8", got.pct, want.pct);
        if (got.cl != want.cl) report_mismatch("fuel_centiliters", got.cl, want.cl);
        if (got.status != want.status)
          report_mismatch("range_status", got.status, want.status);
      end
    end
  end

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    for (int k = 0; k < 5; k++) begin
      if (idx == CURVE_REGS[k]) curve_code[k] = val[CODE_W-1:0];
    end
    if (idx == REG_CAPACITY) tank_cap = val;
  endtask

  task automatic load_curve(input logic [4:0][CODE_W-1:0] codes, input logic [CAP_W-1:0] cap,
                            input bit every);
    for (int k = 0; k < 5; k++) begin
      if (every || $urandom_range(99) < 80)
        write_reg(CURVE_REGS[k], {2'($urandom_range(3)), codes[k]});
    end
    if (every || $urandom_range(99) < 80) write_reg(REG_CAPACITY, cap);
    if (every || $urandom_range(99) < 30)
      write_reg($urandom_range(1) ? REG_SPARE_6 : REG_SPARE_7, CFG_DAT_W'($urandom));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // leaves s_tvalid high so back-to-back requests need no drop
  task automatic send_sample(input logic [ADC_W-1:0] smp);
    if (!no_gaps && $urandom_range(99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0, smp};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    accumulate_sample(smp);
    samples_sent++;
  endtask

  task automatic send_reading(input int target, input int jitter);
    int v;
    for (int n = 0; n < READ_LEN; n++) begin
      v = target + int'($urandom_range(2 * jitter)) - jitter;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      send_sample(v[ADC_W-1:0]);
    end
  endtask

  task automatic drain_readings();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // reset curve: below full, above empty, exactly on the empty point
  task automatic test_reset_curve();
    send_reading(0, 0);
    send_reading(4095, 0);
    send_reading(1415, 0);
    drain_readings();
  endtask

  // zero-width segment reached past non-descending ones, volume saturation,
  // writes to unused indexes
  task automatic test_curve_corners();
    load_curve({12'd100, 12'd900, 12'd900, 12'd800, 12'd500}, 14'd16383, 1'b1);
    send_reading(900, 0);
    send_reading(100, 0);
    drain_readings();
  endtask

  task automatic test_random_curves(input int item_goal);
    logic [4:0][CODE_W-1:0] codes;
    logic [CODE_W-1:0]      tmp;
    logic [CAP_W-1:0]       cap;
    int                     phase;
    int                     phase_end;
    int                     kind;
    int                     mode;
    int                     seg;
    phase = 0;
    while (samples_sent < item_goal) begin
      no_gaps = (phase >= 8 && phase <= 10);
      kind = $urandom_range(9);
      for (int k = 0; k < 5; k++) codes[k] = CODE_W'($urandom_range(4095));
      if (kind <= 5) begin
        for (int a = 0; a < 4; a++) begin
          for (int b = 0; b < 4 - a; b++) begin
            if (codes[b] < codes[b+1]) begin
              tmp = codes[b];
              codes[b] = codes[b+1];
              codes[b+1] = tmp;
            end
          end
        end
        for (int k = 1; k < 5; k++) begin
          if ($urandom_range(99) < 20) codes[k] = codes[k-1];
        end
      end else if (kind == 7) begin
        for (int k = 1; k < 5; k++) codes[k] = codes[0];
      end else if (kind == 8) begin
        case ($urandom_range(2))
          0: codes = {12'd0, 12'd1000, 12'd2000, 12'd3000, 12'd4095};
          1: codes = '0;
          default: codes = '1;
        endcase
      end else if (kind == 9) begin
        codes = {12'd149, 12'd521, 12'd1055, 12'd1241, 12'd1415};
      end
      case ($urandom_range(9))
        0: cap = '0;
        1: cap = '1;
        2: cap = 14'd10000;
        default: cap = CAP_W'($urandom_range(10000));
      endcase
      load_curve(codes, cap, phase == 0);
      phase_end = samples_sent + $urandom_range(30, 80);
      while (samples_sent < phase_end) begin
        mode = $urandom_range(99);
        seg = $urandom_range(3);
        if (mode < 60) begin
          send_reading($urandom_range(curve_code[seg], curve_code[seg+1]),
                       $urandom_range(99) < 25 ? 0 : $urandom_range(1, 3));
        end else if (mode < 70) begin
          send_reading(curve_code[$urandom_range(4)], 0);
        end else if (mode < 85) begin
          for (int n = 0; n < READ_LEN; n++) send_sample(ADC_W'($urandom_range(4095)));
        end else if (mode < 95) begin
          for (int n = 0; n < READ_LEN; n++) send_sample($urandom_range(1) ? '1 : '0);
        end else begin
          // partial reading shifts the alignment of later ones
          repeat ($urandom_range(1, 4)) send_sample(ADC_W'($urandom_range(4095)));
        end
      end
      drain_readings();
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    curve_code = {12'd149, 12'd521, 12'd1055, 12'd1241, 12'd1415};
    tank_cap   = 14'd350;
    acc_sum    = '0;
    acc_count  = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_curve();
    test_curve_corners();
    test_random_curves(1350);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/fgpl_pkg.sv
rtl/fgpl_div.sv
rtl/fuel_gauge_piecewise_linear.sv
test/tb_fuel_gauge_piecewise_linear.sv
